/* src/rau_pkg.sv */
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = 64;
    localparam int CNT_BITS  = 7;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_EQ  = 4'd4,
        OP_NE  = 4'd5,
        OP_GT  = 4'd6,
        OP_GE  = 4'd7,
        OP_LT  = 4'd8,
        OP_LE  = 4'd9
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic load;
        logic mult;
        logic combine;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic quo_load;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic early;
        logic gcd_done;
        logic div_done;
    } stat_t;

endpackage

/* src/rau_datapath.sv */
module rau_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rau_pkg::cmd_t                      cmd,
    output rau_pkg::stat_t                     stat,
    input  logic [3:0]                         operation,
    input  logic signed [rau_pkg::WORD_BITS-1:0] left_num,
    input  logic signed [rau_pkg::WORD_BITS-1:0] left_den,
    input  logic signed [rau_pkg::WORD_BITS-1:0] right_num,
    input  logic signed [rau_pkg::WORD_BITS-1:0] right_den,
    output logic signed [rau_pkg::WORD_BITS-1:0] result_num,
    output logic [rau_pkg::WORD_BITS-2:0]      result_den,
    output logic                               compare_true,
    output logic [1:0]                         status
);
    import rau_pkg::*;

    localparam int W = WORD_BITS;
    localparam int M = MAG_BITS;

    logic [3:0]       op_reg;
    logic             ln_s_reg, rn_s_reg;
    logic [W:0]       lnm_reg, ldm_reg, rnm_reg, rdm_reg;
    logic [1:0]       early_st_reg;
    logic             early_reg;
    logic [M-1:0]     pa_reg, pb_reg, dp_reg;
    logic             sa_reg, sb_reg;
    logic [M-1:0]     mag_reg, den_reg;
    logic             neg_reg;
    logic [M-1:0]     gx_reg, gy_reg;
    logic [M-1:0]     rem_reg, quo_reg;
    logic [6:0]       bit_reg;
    logic             dsel_reg;
    logic [M-1:0]     qmag_reg;

    logic signed [W-1:0] ln_v, ld_v, rn_v, rd_v;
    logic [W:0]       lnm, ldm, rnm, rdm;
    logic             ln_s, rn_s;
    logic             is_cmp, is_div;
    logic [M-1:0]     sub_diff;
    logic             sub_ge;
    logic [M:0]       rem_sh;
    logic             q_bit;
    logic [M-1:0]     rem_nx, quo_nx;
    logic [M-1:0]     lim;
    logic             ovf;

    always_comb
    begin
        ln_v = left_num;
        rn_v = right_num;
        ld_v = left_den;
        rd_v = right_den;
        ln_s = ln_v[W-1] ^ ld_v[W-1];
        rn_s = rn_v[W-1] ^ rd_v[W-1];
        lnm  = ln_v[W-1] ? ({1'b0, ~ln_v} + 1'b1) : {1'b0, ln_v};
        rnm  = rn_v[W-1] ? ({1'b0, ~rn_v} + 1'b1) : {1'b0, rn_v};
        ldm  = ld_v[W-1] ? ({1'b0, ~ld_v} + 1'b1) : {1'b0, ld_v};
        rdm  = rd_v[W-1] ? ({1'b0, ~rd_v} + 1'b1) : {1'b0, rd_v};
        if (lnm == '0) ln_s = 1'b0;
        if (rnm == '0) rn_s = 1'b0;
    end

    assign is_cmp = (op_reg >= OP_EQ) && (op_reg <= OP_LE);
    assign is_div = (op_reg == OP_DIV);

    always_comb
    begin
        sub_ge   = (pa_reg >= pb_reg);
        sub_diff = sub_ge ? (pa_reg - pb_reg) : (pb_reg - pa_reg);
        rem_sh   = {rem_reg, gx_reg[bit_reg[5:0]]};
        q_bit    = (rem_sh >= {1'b0, gy_reg});
        rem_nx   = q_bit ? M'(rem_sh - {1'b0, gy_reg}) : rem_sh[M-1:0];
        quo_nx   = {quo_reg[M-2:0], q_bit};
        lim      = M'(64'd1) << (W - 1);
        ovf      = (den_reg > lim - 1'b1) ||
                   (mag_reg > (neg_reg ? lim : lim - 1'b1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            early_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            early_reg <= (operation > OP_LE) || (ld_v == '0) || (rd_v == '0) ||
                         ((operation == OP_DIV) && (rn_v == '0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            ln_s_reg <= ln_s;
            rn_s_reg <= rn_s;
            lnm_reg  <= lnm;
            rnm_reg  <= rnm;
            ldm_reg  <= ldm;
            rdm_reg  <= rdm;
            early_st_reg <= (operation > OP_LE) ? ST_OK : ST_ZERO_DEN;
        end
        if (cmd.mult)
        begin
            dp_reg <= M'(ldm_reg) * M'(is_div ? rnm_reg : rdm_reg);
            unique case (op_reg)
                OP_MUL:
                begin
                    pa_reg <= M'(lnm_reg) * M'(rnm_reg);
                    sa_reg <= ln_s_reg ^ rn_s_reg;
                end
                OP_DIV:
                begin
                    pa_reg <= M'(lnm_reg) * M'(rdm_reg);
                    sa_reg <= ln_s_reg ^ rn_s_reg;
                end
                default:
                begin
                    pa_reg <= M'(lnm_reg) * M'(rdm_reg);
                    sa_reg <= ln_s_reg;
                end
            endcase
            pb_reg <= M'(rnm_reg) * M'(ldm_reg);
            sb_reg <= rn_s_reg ^ (op_reg == OP_SUB);
        end
        if (cmd.combine)
        begin
            den_reg <= dp_reg;
            if (op_reg == OP_MUL || op_reg == OP_DIV)
            begin
                mag_reg <= pa_reg;
                neg_reg <= sa_reg && (pa_reg != '0);
            end
            else if (sa_reg == sb_reg)
            begin
                mag_reg <= pa_reg + pb_reg;
                neg_reg <= sa_reg && ((pa_reg + pb_reg) != '0);
            end
            else
            begin
                mag_reg <= sub_diff;
                neg_reg <= (sub_ge ? sa_reg : sb_reg) && (sub_diff != '0);
            end
        end
        if (cmd.gcd_init)
        begin
            gx_reg <= mag_reg;
            gy_reg <= den_reg;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            bit_reg  <= 7'(M - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_nx;
            quo_reg <= quo_nx;
            bit_reg <= bit_reg - 1'b1;
        end
        if (cmd.gcd_step)
        begin
            // rem holds gx mod gy
            gx_reg <= gy_reg;
            gy_reg <= rem_reg;
        end
        if (cmd.quo_load)
        begin
            // gx holds the gcd on the first pass; it becomes the divisor
            gx_reg <= dsel_reg ? den_reg : mag_reg;
            if (!dsel_reg) gy_reg <= gx_reg;
        end
        if (cmd.finish)
        begin
            // dsel 0: mag/g, 1: den/g
            if (!dsel_reg)
                qmag_reg <= quo_nx;
            else
            begin
                mag_reg <= qmag_reg;
                den_reg <= quo_nx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dsel_reg <= 1'b0;
        else if (cmd.load)
            dsel_reg <= 1'b0;
        else if (cmd.finish)
            dsel_reg <= ~dsel_reg;
    end

    assign stat.early    = early_reg;
    assign stat.gcd_done = (gy_reg == '0);
    assign stat.div_done = (bit_reg == '0);

    // outputs are combinational from registers that hold while the result waits
    always_comb
    begin
        result_num   = '0;
        result_den   = (W-1)'(1);
        compare_true = 1'b0;
        status       = ST_OK;
        if (early_reg)
        begin
            status = early_st_reg;
        end
        else if (is_cmp)
        begin
            unique case (op_reg)
                OP_EQ:   compare_true = (sa_reg == sb_reg) && (pa_reg == pb_reg) ||
                                        (pa_reg == '0 && pb_reg == '0);
                OP_NE:   compare_true = !((sa_reg == sb_reg) && (pa_reg == pb_reg) ||
                                        (pa_reg == '0 && pb_reg == '0));
                default:
                begin
                    logic gt, eq;
                    eq = ((sa_reg == sb_reg) && (pa_reg == pb_reg)) ||
                         (pa_reg == '0 && pb_reg == '0);
                    if (eq) gt = 1'b0;
                    else if (sa_reg != sb_reg) gt = sb_reg;
                    else gt = sa_reg ? (pa_reg < pb_reg) : (pa_reg > pb_reg);
                    case (op_reg)
                        OP_GT:   compare_true = gt;
                        OP_GE:   compare_true = gt || eq;
                        OP_LT:   compare_true = !gt && !eq;
                        default: compare_true = !gt;
                    endcase
                end
            endcase
        end
        else if (ovf)
        begin
            status = ST_OVERFLOW;
        end
        else
        begin
            result_num = neg_reg ? W'(~mag_reg + 1'b1) : mag_reg[W-1:0];
            result_den = den_reg[W-2:0];
        end
    end

endmodule

/* src/rau_ctrl.sv */
module rau_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    input  rau_pkg::stat_t stat,
    output rau_pkg::cmd_t  cmd
);
    import rau_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_MULT  = 10'b0000000100,
        S_COMB  = 10'b0000001000,
        S_GINIT = 10'b0000010000,
        S_GMOD  = 10'b0000100000,
        S_GSWAP = 10'b0001000000,
        S_QINIT = 10'b0010000000,
        S_QDIV  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            S_CHECK:
                state_next = stat.early ? S_OUT : S_MULT;
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next  = S_GINIT;
            end
            S_GINIT:
            begin
                cmd.gcd_init = 1'b1;
                cmd.div_init = 1'b1;
                phase_next   = 1'b0;
                state_next   = S_GMOD;
            end
            S_GMOD:
                if (stat.gcd_done)
                    state_next = S_QINIT;
                else
                begin
                    cmd.div_step = 1'b1;
                    if (stat.div_done)
                        state_next = S_GSWAP;
                end
            S_GSWAP:
            begin
                cmd.gcd_step = 1'b1;
                cmd.div_init = 1'b1;
                state_next   = S_GMOD;
            end
            S_QINIT:
            begin
                cmd.div_init = 1'b1;
                cmd.quo_load = 1'b1;
                state_next   = S_QDIV;
            end
            S_QDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    if (phase_reg)
                        state_next = S_OUT;
                    else
                    begin
                        phase_next = 1'b1;
                        state_next = S_QINIT;
                    end
                end
            end
            S_OUT:
                if (m_axis_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* src/rational_arithmetic_unit.sv */
// Channel   Dir  Beat contents
// s_axis    in   tdata: operation, left_num, left_den, right_num, right_den
// m_axis    out  tdata: result_num, result_den, compare_true, status
// One item at a time. Unused code, zero denominator, divide by zero: the check state
// sends the controller straight to output. Arithmetic and compares: check, multiply,
// combine and init states, per Euclid remainder a 64-step restoring modulo and a swap,
// a state to see the end, then two 64-step divides (mag/g and den/g) before tvalid.
// Reset returns the controller to idle; tready is high whenever it is idle.
// A stalled result holds m_axis_tdata and blocks the next input beat.
module rational_arithmetic_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[3:0], left_num[35:4], left_den[67:36], right_num[99:68], right_den[131:100]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_num[31:0], result_den[62:32], compare_true[63], status[65:64]
    output logic [71:0]  m_axis_tdata
);
    import rau_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic signed [WORD_BITS-1:0] result_num;
    logic [WORD_BITS-2:0]        result_den;
    logic                        compare_true;
    logic [1:0]                  status;

    rau_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    rau_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (s_axis_tdata[3:0]),
        .left_num     (s_axis_tdata[35:4]),
        .left_den     (s_axis_tdata[67:36]),
        .right_num    (s_axis_tdata[99:68]),
        .right_den    (s_axis_tdata[131:100]),
        .result_num   (result_num),
        .result_den   (result_den),
        .compare_true (compare_true),
        .status       (status)
    );

    assign m_axis_tdata = {6'd0, status, compare_true, result_den, result_num};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while result pending");
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && compare_true |-> result_num == '0 && status == ST_OK)
        else $error("compare result malformed");

endmodule
